### sv/rgbhsv_pkg.sv
// rgbhsv_pkg: word types, widths and codes for the rgb to hsv converter
// no dependencies; imported by rgb_to_hsv_converter_unit
package rgbhsv_pkg;

  // channel width of one color component
  localparam int CHAN_BITS = 8;
  // hue and saturation width
  localparam int FRAC_BITS = 16;
  // quotient bits per division, one more than the fraction for the saturate case
  localparam int QUO_BITS  = FRAC_BITS + 1;
  // hue divisor 6*delta and its remainder
  localparam int HDIV_BITS = CHAN_BITS + 3;
  localparam int HREM_BITS = HDIV_BITS + 1;
  // saturation remainder, below twice the largest channel
  localparam int SREM_BITS = CHAN_BITS + 1;

  typedef logic [CHAN_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_word_t;

  typedef struct packed {
    logic [FRAC_BITS-1:0] hue;
    logic [FRAC_BITS-1:0] saturation;
    chan_t                brightness;
  } hsv_word_t;

  // which channel holds the maximum, ties to red then green
  typedef enum logic [1:0] {
    SEL_RED,
    SEL_GREEN,
    SEL_BLUE
  } max_sel_t;

endpackage

### sv/rgb_to_hsv_converter_unit.sv
// rgb_to_hsv_converter_unit: pipelined rgb to hsv conversion, one pixel per clock
// depends on rgbhsv_pkg (word types, widths, max channel codes)
//
//   channel   ports                        handshake
//   input     start, busy, in_data         taken when start high and busy low
//   result    out_valid, out_data          shown for one cycle, no back pressure
//
// a pixel enters every cycle; busy is always low since nothing downstream stalls
// stages: input register, max select, hue numerator, then
// 17 restoring division steps (one quotient bit each, hue and saturation side by
// side), then the output register; the division chain sets the depth
// rst_n clears the valid bits along the pipe, payload registers are not reset
module rgb_to_hsv_converter_unit
  import rgbhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  rgb_word_t in_data,
  output logic      out_valid,
  output hsv_word_t out_data
);

  // input register
  logic      in_vld_r;
  rgb_word_t in_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
    in_word_r <= in_data;
  end

  assign busy = 1'b0;

  // max select, min and delta
  logic     sel_vld_r;
  max_sel_t sel_r, sel_nxt;
  chan_t    vmax_r, vmax_nxt;
  chan_t    dlt_r, dlt_nxt;
  chan_t    sel_red_r, sel_grn_r, sel_blu_r;

  always_comb begin
    chan_t vmin;
    if (in_word_r.red >= in_word_r.green && in_word_r.red >= in_word_r.blue) begin
      sel_nxt  = SEL_RED;
      vmax_nxt = in_word_r.red;
    end else if (in_word_r.green >= in_word_r.blue) begin
      sel_nxt  = SEL_GREEN;
      vmax_nxt = in_word_r.green;
    end else begin
      sel_nxt  = SEL_BLUE;
      vmax_nxt = in_word_r.blue;
    end
    if (in_word_r.red <= in_word_r.green && in_word_r.red <= in_word_r.blue) begin
      vmin = in_word_r.red;
    end else if (in_word_r.green <= in_word_r.blue) begin
      vmin = in_word_r.green;
    end else begin
      vmin = in_word_r.blue;
    end
    dlt_nxt = vmax_nxt - vmin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else begin
      sel_vld_r <= in_vld_r;
    end
    sel_r     <= sel_nxt;
    vmax_r    <= vmax_nxt;
    dlt_r     <= dlt_nxt;
    sel_red_r <= in_word_r.red;
    sel_grn_r <= in_word_r.green;
    sel_blu_r <= in_word_r.blue;
  end

  // hue numerator and divisor
  logic [HDIV_BITS-1:0] num_nxt, d6_nxt;

  always_comb begin
    logic [HDIV_BITS-1:0] de, re, ge, be;
    de     = HDIV_BITS'(dlt_r);
    re     = HDIV_BITS'(sel_red_r);
    ge     = HDIV_BITS'(sel_grn_r);
    be     = HDIV_BITS'(sel_blu_r);
    d6_nxt = (de << 2) + (de << 1);
    case (sel_r)
      SEL_RED: begin
        if (sel_grn_r >= sel_blu_r) begin
          num_nxt = ge - be;
        end else begin
          num_nxt = d6_nxt - (be - ge);
        end
      end
      SEL_GREEN: num_nxt = (de << 1) + be - re;
      SEL_BLUE:  num_nxt = (de << 2) + re - ge;
      default:   num_nxt = '0;
    endcase
  end

  // division pipe, index 0 is the entry register, QUO_BITS steps follow
  logic                 dv_vld_r  [0:QUO_BITS];
  logic                 dv_gray_r [0:QUO_BITS];
  chan_t                dv_bri_r  [0:QUO_BITS];
  chan_t                dv_sd_r   [0:QUO_BITS];
  logic [HDIV_BITS-1:0] dv_hd_r   [0:QUO_BITS];
  logic [SREM_BITS-1:0] dv_sr_r   [0:QUO_BITS];
  logic [HREM_BITS-1:0] dv_hr_r   [0:QUO_BITS];
  logic [QUO_BITS-1:0]  dv_sq_r   [0:QUO_BITS];
  logic [QUO_BITS-1:0]  dv_hq_r   [0:QUO_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= sel_vld_r;
    end
    dv_gray_r[0] <= (dlt_r == '0);
    dv_bri_r[0]  <= vmax_r;
    dv_sd_r[0]   <= vmax_r;
    dv_hd_r[0]   <= d6_nxt;
    dv_sr_r[0]   <= SREM_BITS'(dlt_r);
    dv_hr_r[0]   <= HREM_BITS'(num_nxt);
    dv_sq_r[0]   <= '0;
    dv_hq_r[0]   <= '0;
  end

  for (genvar s = 0; s < QUO_BITS; s++) begin : g_div
    logic [SREM_BITS-1:0] s_try, s_rem_nxt;
    logic [HREM_BITS-1:0] h_try, h_rem_nxt;
    logic                 s_bit, h_bit;

    // one restoring step: shift in a zero (not on the first step), compare, subtract
    always_comb begin
      if (s == 0) begin
        s_try = dv_sr_r[s];
        h_try = dv_hr_r[s];
      end else begin
        s_try = {dv_sr_r[s][SREM_BITS-2:0], 1'b0};
        h_try = {dv_hr_r[s][HREM_BITS-2:0], 1'b0};
      end
      s_bit     = (s_try >= SREM_BITS'(dv_sd_r[s]));
      h_bit     = (h_try >= HREM_BITS'(dv_hd_r[s]));
      s_rem_nxt = s_bit ? s_try - SREM_BITS'(dv_sd_r[s]) : s_try;
      h_rem_nxt = h_bit ? h_try - HREM_BITS'(dv_hd_r[s]) : h_try;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
      dv_gray_r[s+1] <= dv_gray_r[s];
      dv_bri_r[s+1]  <= dv_bri_r[s];
      dv_sd_r[s+1]   <= dv_sd_r[s];
      dv_hd_r[s+1]   <= dv_hd_r[s];
      dv_sr_r[s+1]   <= s_rem_nxt;
      dv_hr_r[s+1]   <= h_rem_nxt;
      dv_sq_r[s+1]   <= {dv_sq_r[s][QUO_BITS-2:0], s_bit};
      dv_hq_r[s+1]   <= {dv_hq_r[s][QUO_BITS-2:0], h_bit};
    end
  end

  // output register: gray forces zero, full saturation clamps
  logic      out_vld_r;
  hsv_word_t out_word_r, out_word_nxt;

  always_comb begin
    out_word_nxt.brightness = dv_bri_r[QUO_BITS];
    if (dv_gray_r[QUO_BITS]) begin
      out_word_nxt.hue        = '0;
      out_word_nxt.saturation = '0;
    end else begin
      out_word_nxt.hue = dv_hq_r[QUO_BITS][FRAC_BITS-1:0];
      if (dv_sq_r[QUO_BITS][FRAC_BITS]) begin
        out_word_nxt.saturation = '1;
      end else begin
        out_word_nxt.saturation = dv_sq_r[QUO_BITS][FRAC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv_vld_r[QUO_BITS];
    end
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

endmodule
